[src/mtfl_pkg.sv]
package mtfl_pkg;

    // Default sizing of the list.
    localparam int CAPACITY_DEF   = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // Request codes carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_GET    = 2'd1,
        REQ_REWIND = 2'd2,
        REQ_NEXT   = 2'd3
    } t_req;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic capture;  // register compare and cursor pick
        logic apply;    // commit the request to the stored values
        logic do_get;   // request is a get
        logic do_add;   // request is an add
        logic hit;      // some occupied cell matched the key
        logic add_ok;   // add of an absent value with room left
    } t_cell_ctrl;

endpackage

[src/mtfl_cell.sv]
module mtfl_cell #(
    parameter int ELEM_WIDTH = mtfl_pkg::ELEM_WIDTH_DEF,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  mtfl_pkg::t_cell_ctrl   i_ctrl,
    input  logic [ELEM_WIDTH-1:0]  i_key,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [IDX_W-1:0]       i_cursor,
    input  logic [IDX_W-1:0]       i_hit_pos,
    input  logic [ELEM_WIDTH-1:0]  i_prev_value,
    output logic [ELEM_WIDTH-1:0]  o_value,
    output logic                   o_match,
    output logic [ELEM_WIDTH-1:0]  o_pick
);

    logic [ELEM_WIDTH-1:0] r_value;
    logic                  r_match;
    logic [ELEM_WIDTH-1:0] r_pick;
    logic                  occupied;
    logic                  shift_in;
    logic                  append_here;

    assign occupied    = (i_count > CNT_W'(INDEX));
    // On a get hit every cell from the head down to the hit takes its
    // neighbor's value; the head cell's neighbor input carries the key.
    assign shift_in    = i_ctrl.do_get && i_ctrl.hit && (IDX_W'(INDEX) <= i_hit_pos);
    assign append_here = i_ctrl.do_add && i_ctrl.add_ok && (i_count == CNT_W'(INDEX));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_match <= occupied && (r_value == i_key);
            r_pick  <= (occupied && (i_cursor == IDX_W'(INDEX))) ? r_value : '0;
        end
        if (i_ctrl.apply) begin
            if (shift_in) begin
                r_value <= i_prev_value;
            end else if (append_here) begin
                r_value <= i_key;
            end
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;
    assign o_pick  = r_pick;

endmodule

[src/move_to_front_list_unit.sv]
// Channel    Direction  Beat contents
// s_axis     in         tdata: elem_value; tuser: req_type
// m_axis     out        tdata: hit_or_added, value_out, entry_count, more_after,
//                              past_end, list_full (lowest bit first)
//
// Every request passes through the accept cycle, a compare cycle in which each
// cell registers its match bit and its cursor pick, and an apply cycle in which
// the reduced hit decides the shift or append and the result is loaded.
// The apply cycle waits while the output register holds a beat not yet taken.
// Synchronous active-low reset empties the list and parks the cursor at the
// end; the stored values themselves are not cleared.
module move_to_front_list_unit #(
    parameter int CAPACITY   = mtfl_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = mtfl_pkg::ELEM_WIDTH_DEF,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = ((ELEM_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW   = ELEM_WIDTH + CNT_W + 4,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [ELEM_WIDTH-1:0] elem_value, rest zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] hit_or_added, [ELEM_WIDTH:1] value_out, then entry_count (CNT_W bits),
    // more_after, past_end, list_full, rest zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    // Bit offsets of the result fields inside the output beat.
    localparam int OFS_VAL  = 1;
    localparam int OFS_CNT  = OFS_VAL + ELEM_WIDTH;
    localparam int OFS_MORE = OFS_CNT + CNT_W;
    localparam int OFS_PAST = OFS_MORE + 1;
    localparam int OFS_FULL = OFS_PAST + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } t_state;

    t_state                r_state;
    mtfl_pkg::t_req        r_req;
    logic [ELEM_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_cursor;
    logic                  r_cur_valid;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic [CNT_W-1:0]      n_count;
    logic [IDX_W-1:0]      n_cursor;
    logic                  n_cur_valid;
    logic [OUT_W-1:0]      n_out_data;

    logic [ELEM_WIDTH-1:0] cell_value [CAPACITY];
    logic [ELEM_WIDTH-1:0] cell_pick  [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;

    logic                  hit;
    logic [IDX_W-1:0]      hit_pos;
    logic [ELEM_WIDTH-1:0] pick_value;
    logic                  out_free;
    logic                  apply_fire;
    logic                  room_left;
    mtfl_pkg::t_cell_ctrl  ctrl;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign apply_fire    = (r_state == ST_APPLY) && out_free;
    assign room_left     = (r_count < CNT_W'(CAPACITY));

    // Reduce the registered cell outputs. The values are distinct, so at
    // most one match bit is set and at most one pick is nonzero.
    always_comb begin
        hit        = |cell_match;
        hit_pos    = '0;
        pick_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_pos    = hit_pos | (cell_match[i] ? IDX_W'(i) : '0);
            pick_value = pick_value | cell_pick[i];
        end
    end

    always_comb begin
        ctrl.capture = (r_state == ST_MATCH);
        ctrl.apply   = apply_fire;
        ctrl.do_get  = (r_req == mtfl_pkg::REQ_GET);
        ctrl.do_add  = (r_req == mtfl_pkg::REQ_ADD);
        ctrl.hit     = hit;
        ctrl.add_ok  = !hit && room_left;
    end

    // The row of cells. Each cell hands its value to the next one toward
    // the tail; the head cell takes the key in place of a neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] prev_value;
        if (g == 0) begin : g_head
            assign prev_value = r_key;
        end else begin : g_body
            assign prev_value = cell_value[g-1];
        end
        mtfl_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_key        (r_key),
            .i_count      (r_count),
            .i_cursor     (r_cursor),
            .i_hit_pos    (hit_pos),
            .i_prev_value (prev_value),
            .o_value      (cell_value[g]),
            .o_match      (cell_match[g]),
            .o_pick       (cell_pick[g])
        );
    end

    // Result and next cursor and count for the request in the apply cycle.
    always_comb begin
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_cur_valid = r_cur_valid;
        n_out_data  = '0;
        case (r_req)
            mtfl_pkg::REQ_ADD: begin
                if (!hit) begin
                    if (room_left) begin
                        n_count       = r_count + CNT_W'(1);
                        n_out_data[0] = 1'b1;
                    end else begin
                        n_out_data[OFS_FULL] = 1'b1;
                    end
                end
            end
            mtfl_pkg::REQ_GET: begin
                if (hit) begin
                    n_out_data[0]                     = 1'b1;
                    n_out_data[OFS_VAL +: ELEM_WIDTH] = r_key;
                end
            end
            mtfl_pkg::REQ_REWIND: begin
                n_cursor    = '0;
                n_cur_valid = (r_count != '0);
            end
            mtfl_pkg::REQ_NEXT: begin
                if (r_cur_valid && (CNT_W'(r_cursor) < r_count)) begin
                    n_out_data[OFS_VAL +: ELEM_WIDTH] = pick_value;
                    if ((CNT_W'(r_cursor) + CNT_W'(1)) < r_count) begin
                        n_cursor = r_cursor + IDX_W'(1);
                    end else begin
                        n_cur_valid = 1'b0;
                    end
                end else begin
                    n_cur_valid          = 1'b0;
                    n_out_data[OFS_PAST] = 1'b1;
                end
            end
            default: begin
                n_cur_valid = r_cur_valid;
            end
        endcase
        n_out_data[OFS_CNT +: CNT_W] = n_count;
        n_out_data[OFS_MORE]         = n_cur_valid;
    end

    // Sequencer with the list bookkeeping and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces the one being taken in the same cycle.
            if (apply_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req   <= mtfl_pkg::t_req'(s_axis_tuser);
                        r_key   <= s_axis_tdata[ELEM_WIDTH-1:0];
                        r_state <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    r_state <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_cursor    <= n_cursor;
                        r_cur_valid <= n_cur_valid;
                        r_out_data  <= n_out_data;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
